// ----- sv/p2g_pkg.sv -----
// ----------------------------------------------------------------------------
// p2g_pkg: shared types and constants for the pixel to gray converter
// Holds the format codes, the internal operation type, the luma weights and
// the reciprocal constants used to divide by 100 and by 12.
// ----------------------------------------------------------------------------
package p2g_pkg;

    // Gray table size and address width
    localparam int TABLE_ENTRIES = 256;
    localparam int TBL_AW        = $clog2(TABLE_ENTRIES);

    // Configured pixel format codes
    localparam logic [2:0] FMT_MONO  = 3'd0;
    localparam logic [2:0] FMT_PAL   = 3'd1;
    localparam logic [2:0] FMT_555   = 3'd2;
    localparam logic [2:0] FMT_RGB   = 3'd3;
    localparam logic [2:0] FMT_ALPHA = 3'd4;

    // Request kind code on tuser
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_CONVERT = 1'b1;

    // Luma weights for 24-bit and palette loads, and for RGB555
    localparam int W_B    = 11;
    localparam int W_G    = 59;
    localparam int W_R    = 30;
    localparam int W5_B   = 11;
    localparam int W5_G   = 58;
    localparam int W5_R   = 30;

    // Divide by 100: floor(x * 5243 / 2^19), exact for x below 43690
    localparam logic [12:0] RECIP_100  = 13'd5243;
    localparam int          SHIFT_100  = 19;
    // Divide by 12: floor(x * 2731 / 2^15), exact for x below 8192
    localparam logic [12:0] RECIP_12   = 13'd2731;
    localparam int          SHIFT_12   = 15;

    localparam logic [7:0] GRAY_MAX   = 8'd255;
    localparam logic [3:0] MONO_MAX   = 4'd8;

    // Operation decoded from the request and the configured format
    typedef enum logic [2:0] {
        OP_LOAD,
        OP_MONO,
        OP_PAL,
        OP_555,
        OP_RGB,
        OP_ALPHA,
        OP_NONE
    } t_op;

    // Control and payload carried down the pipeline with each request
    typedef struct packed {
        t_op        op;
        logic [7:0] slot;
        logic [7:0] pix;
        logic [3:0] nbits;
        logic       in_range;
    } t_item;

endpackage

// ----- sv/pixel_to_gray_converter_core.sv -----
// A request moves through stages A, B and C into the output register D to give its first result.
// Throughput: one request per cycle unless stalled; a mono byte yields a beat per pixel.
// The output register is the only multi-beat stage, so mono bytes set the sustained rate.
// Reset: synchronous, active low; clears all valid bits and sets the format to 8-bit palette.
// The gray table is not cleared; its entries are undefined until loaded.
// ----------------------------------------------------------------------------
// pixel_to_gray_converter_core
// Four-stage pipeline: weight products, weighted sum, reciprocal multiply,
// then table write/read and the output register with mono bit expansion.
// ----------------------------------------------------------------------------
module pixel_to_gray_converter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,    // pixel_format
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] palette_slot, [15:8] byte0, [23:16] byte1, [31:24] byte2,
    // [39:32] byte3, [43:40] valid_bits, [47:44] zero
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tuser,   // action
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] gray
    output logic        m_axis_tlast    // last
);
    import p2g_pkg::*;

    // Configuration register
    logic [2:0] r_format;

    // Stage registers
    logic        r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    t_item       r_a_item, r_b_item, r_c_item;
    t_item       n_a_item;
    logic [13:0] r_a_p0, r_a_p1, r_a_p2;
    logic [13:0] n_a_p0, n_a_p1, n_a_p2;
    logic [14:0] r_b_sum;
    logic [27:0] r_c_prod;

    // Output stage
    t_op         r_d_op;
    logic [7:0]  r_d_gray;
    logic [7:0]  r_d_bits;
    logic [3:0]  r_d_cnt;
    logic        r_d_in_range;
    logic [7:0]  r_d_blk, r_d_wht;
    logic [7:0]  r_mem_q;

    // Gray table and copies of entries 0 and 1 for mono pixels
    logic [7:0]  r_gray_mem [TABLE_ENTRIES];
    logic [7:0]  r_ent0, r_ent1;

    // Handshake between stages
    logic        d_last_beat, d_free, c_ready, b_ready, a_ready, c_move;
    logic        c_emit, c_write;
    logic [7:0]  c_quot;
    logic [12:0] b_recip;

    // Hold the pixel format
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_PAL;
        end else if (i_cfg_we) begin
            r_format <= i_cfg_wdata;
        end
    end

    // Pipeline flow control
    assign d_last_beat   = (r_d_op != OP_MONO) || (r_d_cnt == 4'd1);
    assign d_free        = !r_d_valid || (m_axis_tready && d_last_beat);
    assign c_ready       = !r_c_valid || d_free;
    assign b_ready       = !r_b_valid || c_ready;
    assign a_ready       = !r_a_valid || b_ready;
    assign s_axis_tready = a_ready;
    assign c_move        = r_c_valid && d_free;

    // Decode the request and form the weighted terms
    always_comb begin
        logic [7:0] b0, b1, b2, b3;
        logic [4:0] c0, c1, c2;
        b0 = s_axis_tdata[15:8];
        b1 = s_axis_tdata[23:16];
        b2 = s_axis_tdata[31:24];
        b3 = s_axis_tdata[39:32];
        c0 = b0[4:0];
        c1 = {b1[1:0], b0[7:5]};
        c2 = b1[6:2];

        n_a_item.slot  = s_axis_tdata[7:0];
        n_a_item.nbits = (s_axis_tdata[43:40] > MONO_MAX) ? MONO_MAX : s_axis_tdata[43:40];
        n_a_item.pix   = b0;
        n_a_item.in_range = ({1'b0, b0} < 9'(TABLE_ENTRIES));

        if (s_axis_tuser == ACT_LOAD) begin
            n_a_item.op = OP_LOAD;
            n_a_item.in_range = ({1'b0, s_axis_tdata[7:0]} < 9'(TABLE_ENTRIES));
        end else begin
            unique case (r_format)
                FMT_MONO:  n_a_item.op = OP_MONO;
                FMT_PAL:   n_a_item.op = OP_PAL;
                FMT_555:   n_a_item.op = OP_555;
                FMT_RGB:   n_a_item.op = OP_RGB;
                FMT_ALPHA: n_a_item.op = OP_ALPHA;
                default:   n_a_item.op = OP_NONE;
            endcase
        end
        if (n_a_item.op == OP_ALPHA) begin
            n_a_item.pix = GRAY_MAX - b3;
        end

        if (n_a_item.op == OP_555) begin
            n_a_p0 = 14'(W5_B * int'(c0));
            n_a_p1 = 14'(W5_G * int'(c1));
            n_a_p2 = 14'(W5_R * int'(c2));
        end else begin
            n_a_p0 = 14'(W_B * int'(b0));
            n_a_p1 = 14'(W_G * int'(b1));
            n_a_p2 = 14'(W_R * int'(b2));
        end
    end

    // Pick the reciprocal for the divider
    assign b_recip = (r_b_item.op == OP_555) ? RECIP_12 : RECIP_100;

    // Quotient from the reciprocal product
    assign c_quot = (r_c_item.op == OP_555) ? 8'(r_c_prod >> SHIFT_12)
                                            : 8'(r_c_prod >> SHIFT_100);

    // Items that produce results enter the output stage; loads write the table
    assign c_emit  = (r_c_item.op == OP_PAL) || (r_c_item.op == OP_555) ||
                     (r_c_item.op == OP_RGB) || (r_c_item.op == OP_ALPHA) ||
                     ((r_c_item.op == OP_MONO) && (r_c_item.nbits != 4'd0));
    assign c_write = c_move && (r_c_item.op == OP_LOAD) && r_c_item.in_range;

    // Advance the arithmetic stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= s_axis_tvalid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a_item <= n_a_item;
            r_a_p0   <= n_a_p0;
            r_a_p1   <= n_a_p1;
            r_a_p2   <= n_a_p2;
        end
        if (b_ready) begin
            r_b_item <= r_a_item;
            r_b_sum  <= {1'b0, r_a_p0} + {1'b0, r_a_p1} + {1'b0, r_a_p2};
        end
        if (c_ready) begin
            r_c_item <= r_b_item;
            r_c_prod <= 28'(r_b_sum) * 28'(b_recip);
        end
    end

    // Write the gray table and keep entries 0 and 1 at hand
    always_ff @(posedge i_clk) begin
        if (c_write) begin
            r_gray_mem[r_c_item.slot[TBL_AW-1:0]] <= c_quot;
            if (r_c_item.slot == 8'd0) begin
                r_ent0 <= c_quot;
            end
            if (r_c_item.slot == 8'd1) begin
                r_ent1 <= c_quot;
            end
        end
    end

    // Read the palette entry as the item enters the output stage
    always_ff @(posedge i_clk) begin
        if (c_move) begin
            r_mem_q <= r_gray_mem[r_c_item.pix[TBL_AW-1:0]];
        end
    end

    // Output register: load a new result or step through mono bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (d_free) begin
            r_d_valid <= r_c_valid && c_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_free) begin
            r_d_op       <= r_c_item.op;
            r_d_gray     <= (r_c_item.op == OP_ALPHA) ? r_c_item.pix : c_quot;
            r_d_bits     <= r_c_item.pix;
            r_d_cnt      <= r_c_item.nbits;
            r_d_in_range <= r_c_item.in_range;
            r_d_blk      <= r_ent0;
            r_d_wht      <= r_ent1;
        end else if (r_d_valid && m_axis_tready) begin
            r_d_bits <= {r_d_bits[6:0], 1'b0};
            r_d_cnt  <= r_d_cnt - 4'd1;
        end
    end

    // Drive the result
    always_comb begin
        unique case (r_d_op)
            OP_MONO: m_axis_tdata = r_d_bits[7] ? r_d_wht : r_d_blk;
            OP_PAL:  m_axis_tdata = r_d_in_range ? r_mem_q : 8'd0;
            default: m_axis_tdata = r_d_gray;
        endcase
    end

    assign m_axis_tvalid = r_d_valid;
    assign m_axis_tlast  = d_last_beat;

`ifndef SYNTHESIS
    // A mono result in the output stage always has pixels left
    a_mono_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_valid && (r_d_op == OP_MONO)) |-> (r_d_cnt != 4'd0))
        else $error("mono result with zero pixel count");

    // A non-last mono beat taken leaves the stage valid with one pixel fewer
    a_mono_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (r_d_valid && (r_d_cnt == $past(r_d_cnt) - 4'd1)))
        else $error("mono beat did not advance");

    // Back-pressure only when the entry stage holds a request
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_a_valid)
        else $error("request stalled with empty entry stage");
`endif

endmodule

// ----- bench/p2g_gray_checker.sv -----
// ----------------------------------------------------------------------------
// p2g_gray_checker: scoreboard for the pixel to gray converter
// Watches the configuration port and both stream channels, keeps a shadow of
// the pixel format and the gray table, predicts the gray results of every
// accepted request and compares each accepted result, in order, field by field.
// ----------------------------------------------------------------------------
module p2g_gray_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [47:0] i_req_data,
    input  logic        i_req_user,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [7:0]  i_res_data,
    input  logic        i_res_last,
    output int          o_fail_count,
    output int          o_pending
);
    import p2g_pkg::*;

    typedef struct packed {
        logic [7:0] gray;
        logic       last;
    } t_gray_result;

    t_gray_result expected_gray_q[$];
    logic [7:0]   shadow_gray_table [TABLE_ENTRIES];
    logic [2:0]   shadow_format;

    // Weighted luma of three color bytes, floor divided by 100
    function automatic logic [7:0] weigh_luma(input logic [7:0] b, input logic [7:0] g,
                                              input logic [7:0] r);
        int unsigned sum;
        sum = 11 * b + 59 * g + 30 * r;
        return 8'(sum / 100);
    endfunction

    // Out-of-range indexes read as zero
    function automatic logic [7:0] table_lookup(input int unsigned idx);
        if (idx < TABLE_ENTRIES)
            return shadow_gray_table[idx];
        return 8'd0;
    endfunction

    // Update the shadow table or queue the gray values one request produces
    task automatic predict_gray_results(input logic act, input logic [47:0] d);
        logic [7:0]   slot;
        logic [7:0]   b0;
        logic [7:0]   b1;
        logic [7:0]   b2;
        logic [7:0]   b3;
        logic [3:0]   nbits;
        logic [15:0]  word555;
        int unsigned  sum555;
        int           count;
        t_gray_result res;
        slot  = d[7:0];
        b0    = d[15:8];
        b1    = d[23:16];
        b2    = d[31:24];
        b3    = d[39:32];
        nbits = d[43:40];
        if (act == ACT_LOAD) begin
            if (slot < TABLE_ENTRIES)
                shadow_gray_table[slot] = weigh_luma(b0, b1, b2);
            return;
        end
        case (shadow_format)
            FMT_MONO: begin
                // Expand MSB first, saturate the pixel count at eight
                count = (nbits > 8) ? 8 : int'(nbits);
                for (int i = 0; i < count; i++) begin
                    res.gray = b0[7 - i] ? table_lookup(1) : table_lookup(0);
                    res.last = (i == count - 1);
                    expected_gray_q.push_back(res);
                end
            end
            FMT_PAL: begin
                res.gray = table_lookup(b0);
                res.last = 1'b1;
                expected_gray_q.push_back(res);
            end
            FMT_555: begin
                word555  = {b1, b0};
                sum555   = 11 * word555[4:0] + 58 * word555[9:5] + 30 * word555[14:10];
                res.gray = 8'(sum555 / 12);
                res.last = 1'b1;
                expected_gray_q.push_back(res);
            end
            FMT_RGB: begin
                res.gray = weigh_luma(b0, b1, b2);
                res.last = 1'b1;
                expected_gray_q.push_back(res);
            end
            FMT_ALPHA: begin
                res.gray = 8'd255 - b3;
                res.last = 1'b1;
                expected_gray_q.push_back(res);
            end
            default: begin
                // Reserved formats drop convert requests
            end
        endcase
    endtask

    // Sample all channels on the rising edge
    always @(posedge i_clk) begin : watch
        t_gray_result want;
        if (!i_rst_n) begin
            shadow_format = FMT_PAL;
            o_fail_count  = 0;
            expected_gray_q.delete();
            for (int i = 0; i < TABLE_ENTRIES; i++)
                shadow_gray_table[i] = 8'd0;
        end else begin
            // Compare results before queueing new predictions
            if (i_res_valid && i_res_ready) begin
                if (expected_gray_q.size() == 0) begin
                    $error("unexpected result: gray %0d last %0b", i_res_data, i_res_last);
                    o_fail_count++;
                end else begin
                    want = expected_gray_q.pop_front();
                    if (i_res_data !== want.gray) begin
                        $error("gray: expected %0d, actual %0d", want.gray, i_res_data);
                        o_fail_count++;
                    end
                    if (i_res_last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, i_res_last);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we)
                shadow_format = i_cfg_wdata;
            if (i_req_valid && i_req_ready)
                predict_gray_results(i_req_user, i_req_data);
        end
        o_pending = expected_gray_q.size();
    end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for pixel_to_gray_converter_core
// Loads gray table entries and streams pixels in every format, first directed
// corner cases, then random phases with idle gaps on the request stream and
// back-pressure on the result stream. The checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module testbench;
    import p2g_pkg::*;

    // Reserved format codes, which drop convert requests
    localparam logic [2:0] FMT_RSVD_LO  = 3'd5;
    localparam logic [2:0] FMT_RSVD_MID = 3'd6;
    localparam logic [2:0] FMT_RSVD_HI  = 3'd7;

    localparam int PHASE_COUNT = 10;
    localparam int PHASE_ITEMS = 19;
    localparam int SETTLE_CYCLES = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    int          mismatch_count;
    int          results_pending;
    logic        sender_steady;
    logic        sink_steady;
    bit          slot_loaded [TABLE_ENTRIES];
    logic [7:0]  loaded_slots[$];

    pixel_to_gray_converter_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    p2g_gray_checker gray_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_user   (s_axis_tuser),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_last   (m_axis_tlast),
        .o_fail_count (mismatch_count),
        .o_pending    (results_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop for a hung run
    initial begin
        #2000000;
        $display("testbench: FAIL");
        $finish;
    end

    // Stall the result stream at random, about 8 percent of the time, unless sink_steady is set
    always @(negedge i_clk)
        m_axis_tready <= sink_steady || ($urandom_range(99) >= 8);

    // Offer one request, with random idle cycles ahead of it, and hold until taken
    task automatic send_request(input logic act, input logic [7:0] slot, input logic [7:0] b0,
                                input logic [7:0] b1, input logic [7:0] b2,
                                input logic [7:0] b3, input logic [3:0] nbits);
        while (!sender_steady && $urandom_range(99) < 8) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {4'd0, nbits, b3, b2, b1, b0, slot};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write a gray table entry and remember that it holds a value
    task automatic load_entry(input logic [7:0] slot, input logic [7:0] b0,
                              input logic [7:0] b1, input logic [7:0] b2);
        send_request(ACT_LOAD, slot, b0, b1, b2, 8'($urandom), 4'($urandom));
        if (!slot_loaded[slot]) begin
            slot_loaded[slot] = 1'b1;
            loaded_slots.push_back(slot);
        end
    endtask

    // Drop valid, wait out every expected result, then let the pipeline empty
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (results_pending != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_format(input logic [2:0] fmt);
        settle_idle();
        i_cfg_wdata <= fmt;
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        logic [2:0] phase_formats [PHASE_COUNT];
        logic [2:0] fmt;
        logic [7:0] pix;
        logic [3:0] nbits;

        phase_formats = '{FMT_PAL, FMT_MONO, FMT_555, FMT_RGB, FMT_ALPHA,
                          FMT_PAL, FMT_MONO, FMT_RSVD_LO, FMT_RSVD_MID, FMT_PAL};

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 3'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 48'd0;
        s_axis_tuser  = ACT_LOAD;
        sender_steady = 1'b0;
        sink_steady   = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: table loads at the extremes of slot and color bytes
        write_format(FMT_PAL);
        load_entry(8'd0,   8'd0,   8'd0,   8'd0);
        load_entry(8'd1,   8'd255, 8'd255, 8'd255);
        load_entry(8'd255, 8'd255, 8'd0,   8'd0);
        load_entry(8'd128, 8'd0,   8'd255, 8'd0);
        load_entry(8'd2,   8'd0,   8'd0,   8'd255);
        // Palette reads of entries 0, 1, 255 and 128 loaded above
        send_request(ACT_CONVERT, 8'd0, 8'd0,   8'd0, 8'd0, 8'd0, 4'd1);
        send_request(ACT_CONVERT, 8'd0, 8'd1,   8'd0, 8'd0, 8'd0, 4'd1);
        send_request(ACT_CONVERT, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 4'd1);
        send_request(ACT_CONVERT, 8'd0, 8'd128, 8'd0, 8'd0, 8'd0, 4'd1);

        // Mono: full byte, single pixel, zero count, count above eight
        write_format(FMT_MONO);
        send_request(ACT_CONVERT, 8'd0, 8'hA5, 8'd0, 8'd0, 8'd0, 4'd8);
        send_request(ACT_CONVERT, 8'd0, 8'hFF, 8'd0, 8'd0, 8'd0, 4'd1);
        send_request(ACT_CONVERT, 8'd0, 8'h00, 8'd0, 8'd0, 8'd0, 4'd0);
        send_request(ACT_CONVERT, 8'd0, 8'h5A, 8'd0, 8'd0, 8'd0, 4'd15);

        // RGB555: all ones with the unused top bit set, zero, full scale
        write_format(FMT_555);
        send_request(ACT_CONVERT, 8'd0, 8'hFF, 8'hFF, 8'd0, 8'd0, 4'd1);
        send_request(ACT_CONVERT, 8'd0, 8'h00, 8'h00, 8'd0, 8'd0, 4'd1);
        send_request(ACT_CONVERT, 8'd0, 8'hFF, 8'h7F, 8'd0, 8'd0, 4'd1);

        write_format(FMT_RGB);
        send_request(ACT_CONVERT, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 4'd1);
        send_request(ACT_CONVERT, 8'd0, 8'd0,   8'd0,   8'd0,   8'd0, 4'd1);

        write_format(FMT_ALPHA);
        send_request(ACT_CONVERT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,   4'd1);
        send_request(ACT_CONVERT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 4'd1);

        // Reserved format drops converts but still takes loads
        write_format(FMT_RSVD_HI);
        send_request(ACT_CONVERT, 8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 4'd8);
        load_entry(8'd3, 8'd10, 8'd20, 8'd30);
        write_format(FMT_PAL);
        send_request(ACT_CONVERT, 8'd0, 8'd3, 8'd0, 8'd0, 8'd0, 4'd1);

        // Random phases, one format each
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            fmt = phase_formats[ph];
            write_format(fmt);
            sender_steady = (ph == 2);
            sink_steady   = (ph == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 5 && n == 10)
                    settle_idle();
                if ($urandom_range(99) < 30) begin
                    load_entry(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                end else begin
                    pix = 8'($urandom);
                    if (fmt == FMT_PAL)
                        pix = loaded_slots[$urandom_range(loaded_slots.size() - 1)];
                    if ($urandom_range(99) < 85)
                        nbits = 4'($urandom_range(8, 1));
                    else
                        nbits = 4'($urandom_range(15));
                    send_request(ACT_CONVERT, 8'($urandom), pix, 8'($urandom),
                                 8'($urandom), 8'($urandom), nbits);
                end
            end
        end
        sender_steady = 1'b0;
        sink_steady   = 1'b0;

        // Drain and give the verdict
        settle_idle();
        if (mismatch_count == 0 && results_pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
